/* src/ptw_pkg.sv */
package ptw_pkg;

    localparam int unsigned VA_W    = 48;
    localparam int unsigned PA_W    = 52;
    localparam int unsigned ENTRY_W = 64;
    localparam int unsigned IDX_W   = 9;

    localparam int unsigned BIT_PRESENT = 0;
    localparam int unsigned BIT_HUGE    = 7;

    typedef enum logic
    {
        REQ_TRANSLATE = 1'b0,
        REQ_ENTRY     = 1'b1
    } req_kind_t;

    typedef enum logic
    {
        OUT_READ = 1'b0,
        OUT_DONE = 1'b1
    } out_kind_t;

    typedef enum logic [1:0]
    {
        LVL_PT   = 2'd0,
        LVL_PD   = 2'd1,
        LVL_PDPT = 2'd2,
        LVL_PML4 = 2'd3
    } level_t;

    typedef struct packed
    {
        logic               req_type;
        logic [VA_W-1:0]    virt_addr;
        logic [ENTRY_W-1:0] entry_data;
    } req_t;

    typedef struct packed
    {
        logic            out_kind;
        logic [PA_W-1:0] read_addr;
        logic [PA_W-1:0] phys_addr;
        logic            fault;
    } rsp_t;

    typedef struct packed
    {
        logic valid;
        req_t item;
    } stage_t;

    typedef struct packed
    {
        logic load;
        rsp_t rsp;
    } load_t;

endpackage

/* src/ptw_if.sv */
interface ptw_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [ptw_pkg::VA_W-1:0]     virt_addr;
    logic [ptw_pkg::ENTRY_W-1:0]  entry_data;

    modport source (output valid, output req_type, output virt_addr, output entry_data,
                    input ready);
    modport sink   (input valid, input req_type, input virt_addr, input entry_data,
                    output ready);
endinterface

interface ptw_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      out_kind;
    logic [ptw_pkg::PA_W-1:0]  read_addr;
    logic [ptw_pkg::PA_W-1:0]  phys_addr;
    logic                      fault;

    modport source (output valid, output out_kind, output read_addr, output phys_addr,
                    output fault, input ready);
    modport sink   (input valid, input out_kind, input read_addr, input phys_addr,
                    input fault, output ready);
endinterface

/* src/ptw_in_reg.sv */
module ptw_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    ptw_req_if.sink           req,
    input  logic              consume,
    output ptw_pkg::stage_t   stage
);

    logic          valid_reg;
    logic          valid_next;
    ptw_pkg::req_t item_reg;
    logic          accept;

    assign req.ready = !valid_reg || consume;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req_type   <= req.req_type;
            item_reg.virt_addr  <= req.virt_addr;
            item_reg.entry_data <= req.entry_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

/* src/ptw_walk.sv */
module ptw_walk
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [ptw_pkg::PA_W-1:0] cfg_data,
    input  ptw_pkg::stage_t          stage,
    input  logic                     out_free,
    output logic                     consume,
    output ptw_pkg::load_t           load
);

    logic [ptw_pkg::PA_W-1:0]    root_reg;
    logic                        busy_reg;
    logic                        busy_next;
    ptw_pkg::level_t             level_reg;
    ptw_pkg::level_t             level_next;
    logic [ptw_pkg::VA_W-1:0]    virt_reg;
    logic [ptw_pkg::VA_W-1:0]    virt_next;

    logic [ptw_pkg::VA_W-1:0]    va;
    logic [ptw_pkg::ENTRY_W-1:0] e;
    logic                        present;
    logic                        huge;
    ptw_pkg::rsp_t               rsp;
    logic                        emit;

    assign consume = stage.valid && out_free;
    assign va      = stage.item.virt_addr;
    assign e       = stage.item.entry_data;
    assign present = e[ptw_pkg::BIT_PRESENT];
    assign huge    = e[ptw_pkg::BIT_HUGE];

    always_comb
    begin
        busy_next     = busy_reg;
        level_next    = level_reg;
        virt_next     = virt_reg;
        emit          = 1'b0;
        rsp.out_kind  = ptw_pkg::OUT_READ;
        rsp.read_addr = '0;
        rsp.phys_addr = '0;
        rsp.fault     = 1'b0;
        if (consume)
        begin
            if (stage.item.req_type == ptw_pkg::REQ_TRANSLATE)
            begin
                virt_next     = va;
                busy_next     = 1'b1;
                level_next    = ptw_pkg::LVL_PML4;
                emit          = 1'b1;
                rsp.read_addr = {root_reg[51:12], va[47:39], 3'b000};
            end
            else if (busy_reg)
            begin
                emit = 1'b1;
                if (!present)
                begin
                    busy_next    = 1'b0;
                    level_next   = ptw_pkg::LVL_PT;
                    rsp.out_kind = ptw_pkg::OUT_DONE;
                    rsp.fault    = 1'b1;
                end
                else
                begin
                    unique case (level_reg)
                        ptw_pkg::LVL_PML4:
                        begin
                            level_next    = ptw_pkg::LVL_PDPT;
                            rsp.read_addr = {e[51:12], virt_reg[38:30], 3'b000};
                        end
                        ptw_pkg::LVL_PDPT:
                        begin
                            if (huge)
                            begin
                                busy_next     = 1'b0;
                                level_next    = ptw_pkg::LVL_PT;
                                rsp.out_kind  = ptw_pkg::OUT_DONE;
                                rsp.phys_addr = {e[51:30], virt_reg[29:0]};
                            end
                            else
                            begin
                                level_next    = ptw_pkg::LVL_PD;
                                rsp.read_addr = {e[51:12], virt_reg[29:21], 3'b000};
                            end
                        end
                        ptw_pkg::LVL_PD:
                        begin
                            if (huge)
                            begin
                                busy_next     = 1'b0;
                                level_next    = ptw_pkg::LVL_PT;
                                rsp.out_kind  = ptw_pkg::OUT_DONE;
                                rsp.phys_addr = {e[51:21], virt_reg[20:0]};
                            end
                            else
                            begin
                                level_next    = ptw_pkg::LVL_PT;
                                rsp.read_addr = {e[51:12], virt_reg[20:12], 3'b000};
                            end
                        end
                        ptw_pkg::LVL_PT:
                        begin
                            busy_next     = 1'b0;
                            rsp.out_kind  = ptw_pkg::OUT_DONE;
                            rsp.phys_addr = {e[51:12], virt_reg[11:0]};
                        end
                        default:
                        begin
                            busy_next = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg  <= '0;
            busy_reg  <= 1'b0;
            level_reg <= ptw_pkg::LVL_PT;
            virt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                root_reg <= cfg_data;
            end
            busy_reg  <= busy_next;
            level_reg <= level_next;
            virt_reg  <= virt_next;
        end
    end

    assign load.load = emit;
    assign load.rsp  = rsp;

endmodule

/* src/ptw_out_reg.sv */
module ptw_out_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  ptw_pkg::load_t  load,
    output logic            out_free,
    ptw_rsp_if.source       rsp
);

    logic          valid_reg;
    logic          valid_next;
    ptw_pkg::rsp_t data_reg;

    assign out_free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load.load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.load)
        begin
            data_reg <= load.rsp;
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.out_kind  = data_reg.out_kind;
    assign rsp.read_addr = data_reg.read_addr;
    assign rsp.phys_addr = data_reg.phys_addr;
    assign rsp.fault     = data_reg.fault;

endmodule

/* src/four_level_page_table_walker_top.sv */
// Four-level page-table walker. A translate transaction on req starts a walk and
// yields the read request for the top-level entry; each entry transaction that follows
// yields the next read request or the finished translation (1 GiB, 2 MiB or 4 KiB, or
// a fault with address 0). An entry that arrives with no walk running is dropped. One
// transaction is accepted every cycle; its result passes from the input register into
// the result register, which drives rsp, and the rate drops only while rsp is stalled.
// cfg_we writes the root table address; write it only while idle.
module four_level_page_table_walker_top
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [ptw_pkg::PA_W-1:0] cfg_data,
    ptw_req_if.sink                  req,
    ptw_rsp_if.source                rsp
);

    ptw_pkg::stage_t stage;
    ptw_pkg::load_t  load;
    logic            consume;
    logic            out_free;

    ptw_in_reg u_in_reg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .consume (consume),
        .stage   (stage)
    );

    ptw_walk u_walk
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .stage    (stage),
        .out_free (out_free),
        .consume  (consume),
        .load     (load)
    );

    ptw_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .out_free (out_free),
        .rsp      (rsp)
    );

    a_fault_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.fault |->
            rsp.out_kind == ptw_pkg::OUT_DONE && rsp.phys_addr == '0 && rsp.read_addr == '0)
        else $error("fault result carries an address");

    a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.out_kind == ptw_pkg::OUT_READ |->
            !rsp.fault && rsp.phys_addr == '0 && rsp.read_addr[2:0] == 3'b000)
        else $error("malformed read request");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> stage.valid && rsp.valid && !rsp.ready)
        else $error("input stalled without a full pipeline");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !load.load)
        else $error("result register overwritten while stalled");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_WAIT  = 4;
    localparam int PA_W        = ptw_pkg::PA_W;
    localparam int VA_W        = ptw_pkg::VA_W;
    localparam int IDX_W       = ptw_pkg::IDX_W;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [PA_W-1:0] cfg_data;

    ptw_req_if req_ch ();
    ptw_rsp_if rsp_ch ();

    four_level_page_table_walker_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [PA_W-1:0]  root_table;
    logic             walk_active;
    ptw_pkg::level_t  walk_lvl;
    logic [VA_W-1:0]  walk_va;

    ptw_pkg::rsp_t expected_rsps[$];
    int   check_failures = 0;
    int   walk_results   = 0;
    bit   req_gaps       = 1'b1;
    bit   rsp_gaps       = 1'b1;
    int   rsp_hold_cycles = 0;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [PA_W-1:0] entry_slot(logic [PA_W-1:0] base, logic [VA_W-1:0] va,
                                                   ptw_pkg::level_t lvl);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(va >> (12 + 9 * int'(lvl)));
        return {base[PA_W-1:12], 12'h000} + PA_W'({idx, 3'b000});
    endfunction

    task automatic advance_walk(input ptw_pkg::req_t it);
        ptw_pkg::rsp_t r;
        logic          produces;
        logic [63:0]   e;
        r = '0;
        produces = 1'b1;
        e = it.entry_data;
        if (it.req_type == ptw_pkg::REQ_TRANSLATE)
        begin
            walk_va = it.virt_addr;
            walk_active = 1'b1;
            walk_lvl = ptw_pkg::LVL_PML4;
            r.out_kind = ptw_pkg::OUT_READ;
            r.read_addr = entry_slot(root_table, walk_va, ptw_pkg::LVL_PML4);
        end
        else if (!walk_active)
        begin
            produces = 1'b0;
        end
        else if (!e[ptw_pkg::BIT_PRESENT])
        begin
            walk_active = 1'b0;
            walk_lvl = ptw_pkg::LVL_PT;
            r.out_kind = ptw_pkg::OUT_DONE;
            r.fault = 1'b1;
        end
        else if (walk_lvl == ptw_pkg::LVL_PDPT && e[ptw_pkg::BIT_HUGE])
        begin
            walk_active = 1'b0;
            walk_lvl = ptw_pkg::LVL_PT;
            r.out_kind = ptw_pkg::OUT_DONE;
            r.phys_addr = {e[PA_W-1:30], walk_va[29:0]};
        end
        else if (walk_lvl == ptw_pkg::LVL_PD && e[ptw_pkg::BIT_HUGE])
        begin
            walk_active = 1'b0;
            walk_lvl = ptw_pkg::LVL_PT;
            r.out_kind = ptw_pkg::OUT_DONE;
            r.phys_addr = {e[PA_W-1:21], walk_va[20:0]};
        end
        else if (walk_lvl == ptw_pkg::LVL_PT)
        begin
            walk_active = 1'b0;
            r.out_kind = ptw_pkg::OUT_DONE;
            r.phys_addr = {e[PA_W-1:12], walk_va[11:0]};
        end
        else
        begin
            walk_lvl = ptw_pkg::level_t'(walk_lvl - 2'd1);
            r.out_kind = ptw_pkg::OUT_READ;
            r.read_addr = entry_slot(e[PA_W-1:0], walk_va, walk_lvl);
        end
        if (produces)
        begin
            expected_rsps.push_back(r);
            walk_results++;
        end
    endtask

    task automatic send_item(input ptw_pkg::req_t it);
        int gap;
        gap = req_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid = 1'b1;
        req_ch.req_type = it.req_type;
        req_ch.virt_addr = it.virt_addr;
        req_ch.entry_data = it.entry_data;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        advance_walk(it);
    endtask

    task automatic send_translate(input logic [VA_W-1:0] va);
        ptw_pkg::req_t it;
        it = '0;
        it.req_type = ptw_pkg::REQ_TRANSLATE;
        it.virt_addr = va;
        it.entry_data = rand64();
        send_item(it);
    endtask

    task automatic send_entry(input logic [63:0] e);
        ptw_pkg::req_t it;
        it = '0;
        it.req_type = ptw_pkg::REQ_ENTRY;
        it.virt_addr = VA_W'(rand64());
        it.entry_data = e;
        send_item(it);
    endtask

    // hold the request side until every pending result has come back
    task automatic drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_rsps.size() != 0) @(posedge clk);
    endtask

    task automatic set_root(input logic [PA_W-1:0] value);
        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        root_table = value;
    endtask

    task automatic test_idle_entries_root_zero();
        send_entry('1);
        send_entry('0);
        send_translate('0);
        send_entry('0);
        send_entry(64'h1);
        drain();
    endtask

    task automatic test_extreme_addresses();
        set_root('1);
        send_translate('1);
        send_entry('1);
        send_entry('1);
        send_translate('1);
        send_entry(64'h1);
        send_entry(64'hFFFF_FFFF_FFFF_FF7F);
        send_entry(64'hFFFF_FFFF_FFFF_FF7F);
        send_entry('1);
        drain();
    endtask

    task automatic test_huge_pages();
        set_root(PA_W'(rand64()));
        send_translate(VA_W'(rand64()));
        send_entry(rand64() | 64'h1);
        send_entry(rand64() | 64'h81);
        send_translate(VA_W'(rand64()));
        send_entry(rand64() | 64'h1);
        send_entry((rand64() | 64'h1) & ~64'h80);
        send_entry(rand64() | 64'h81);
        drain();
    endtask

    task automatic test_faults();
        send_translate(VA_W'(rand64()));
        send_entry(64'h1);
        send_entry(64'hFFFF_FFFF_FFFF_FFFE);
        send_translate(VA_W'(rand64()));
        send_entry(64'h1);
        send_entry(64'h1);
        send_entry(64'hFFFF_FFFF_FFFF_FFFE);
        send_translate(VA_W'(rand64()));
        send_entry(64'h1);
        send_entry(64'h1);
        send_entry(64'h1);
        send_entry(64'h0);
        drain();
    endtask

    task automatic test_restart_while_busy();
        send_translate(VA_W'(rand64()));
        send_entry(rand64() | 64'h1);
        send_translate(VA_W'(rand64()));
        send_translate(VA_W'(rand64()));
        send_entry(rand64() | 64'h1);
        send_entry((rand64() | 64'h1) & ~64'h80);
        send_entry((rand64() | 64'h1) & ~64'h80);
        send_entry(rand64());
        drain();
    endtask

    task automatic random_walk();
        logic [63:0] e;
        send_translate(VA_W'(rand64()));
        while (walk_active)
        begin
            if ($urandom_range(0, 39) == 0)
                return;
            e = rand64();
            e[ptw_pkg::BIT_PRESENT] = ($urandom_range(0, 11) != 0);
            e[ptw_pkg::BIT_HUGE] = ($urandom_range(0, 2) == 0);
            send_entry(e);
        end
        if ($urandom_range(0, 9) == 0)
            send_entry(rand64());
    endtask

    task automatic test_backpressure();
        req_gaps = 1'b0;
        rsp_hold_cycles = LONG_HOLD;
        for (int i = 0; i < 12; i++)
            random_walk();
        drain();
        req_gaps = 1'b1;
    endtask

    task automatic test_random_walks();
        int stop;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_root('0);
                1: set_root('1);
                default: set_root(PA_W'(rand64()));
            endcase
            req_gaps = (p % 3 != 1);
            rsp_gaps = (p % 3 == 0);
            stop = walk_results + 200;
            while (walk_results < stop)
            begin
                random_walk();
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end
        req_gaps = 1'b1;
        rsp_gaps = 1'b1;
        drain();
    endtask

    task automatic check_result();
        ptw_pkg::rsp_t got;
        ptw_pkg::rsp_t want;
        got.out_kind = rsp_ch.out_kind;
        got.read_addr = rsp_ch.read_addr;
        got.phys_addr = rsp_ch.phys_addr;
        got.fault = rsp_ch.fault;
        if (expected_rsps.size() == 0)
        begin
            check_failures++;
            if (check_failures <= 10)
                $display("unexpected result: kind %0b read %h phys %h fault %0b",
                         got.out_kind, got.read_addr, got.phys_addr, got.fault);
            return;
        end
        want = expected_rsps.pop_front();
        if (got.out_kind !== want.out_kind || got.read_addr !== want.read_addr ||
            got.phys_addr !== want.phys_addr || got.fault !== want.fault)
        begin
            check_failures++;
            if (check_failures <= 10)
                $display("mismatch: expected %0b/%h/%h/%0b, got %0b/%h/%h/%0b",
                         want.out_kind, want.read_addr, want.phys_addr, want.fault,
                         got.out_kind, got.read_addr, got.phys_addr, got.fault);
        end
    endtask

    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                stall = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
            begin
                stall = rsp_gaps ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ch.ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready = 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            check_result();
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = ptw_pkg::REQ_TRANSLATE;
        req_ch.virt_addr = '0;
        req_ch.entry_data = '0;
        root_table = '0;
        walk_active = 1'b0;
        walk_lvl = ptw_pkg::LVL_PT;
        walk_va = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_entries_root_zero();
        test_extreme_addresses();
        test_huge_pages();
        test_faults();
        test_restart_while_busy();
        test_backpressure();
        test_random_walks();

        drain();
        repeat (8) @(posedge clk);
        if (check_failures == 0 && expected_rsps.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
src/ptw_pkg.sv
src/ptw_if.sv
src/ptw_in_reg.sv
src/ptw_walk.sv
src/ptw_out_reg.sv
src/four_level_page_table_walker_top.sv
tb/testbench.sv
